// File: design/dpms_pkg.sv
// Shared types, codes and helpers for the DNA profile motif scanner.
package dpms_pkg;

	localparam int MAX_MOTIF_DEF    = 30;
	localparam int MAX_SEQUENCE_DEF = 16384;

	localparam int WEIGHT_W   = 17;
	localparam int BASE_W     = 2;
	localparam int CHAR_W     = 8;
	localparam int COL_W      = 5;
	localparam int OP_W       = 2;
	localparam int LEN_REG_W  = 5;
	localparam int THR_W      = 17;
	localparam int POS_W      = 15;
	localparam int SKIP_W     = 5;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 17;

	localparam logic [LEN_REG_W-1:0] LEN_RESET = 5'd30;
	localparam logic [THR_W-1:0]     THR_RESET = 17'd65536;

	localparam logic [OP_W-1:0] OP_LOAD = 2'd0;
	localparam logic [OP_W-1:0] OP_SCAN = 2'd1;
	localparam logic [OP_W-1:0] OP_NEW  = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_LENGTH    = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 1'd1;

	localparam logic [CHAR_W-1:0] CHAR_C = 8'h43;
	localparam logic [CHAR_W-1:0] CHAR_G = 8'h47;
	localparam logic [CHAR_W-1:0] CHAR_T = 8'h54;

	typedef logic [BASE_W-1:0]   base_t;
	typedef logic [WEIGHT_W-1:0] weight_t;
	typedef logic [POS_W-1:0]    pos_t;
	typedef logic [SKIP_W-1:0]   skip_t;

	localparam base_t BASE_A = 2'd0;
	localparam base_t BASE_C = 2'd1;
	localparam base_t BASE_G = 2'd2;
	localparam base_t BASE_T = 2'd3;

	typedef struct packed {
		logic               load;
		logic [COL_W-1:0]   column;
		base_t              wbase;
		weight_t            value;
		logic               shift;
		base_t              new_base;
		logic               clear;
	} cell_ctl_t;

	function automatic base_t base_code(input logic [CHAR_W-1:0] ch);
		base_t code;
		case (ch)
			CHAR_C:  code = BASE_C;
			CHAR_G:  code = BASE_G;
			CHAR_T:  code = BASE_T;
			default: code = BASE_A;
		endcase
		return code;
	endfunction

endpackage

// File: design/dna_profile_motif_scanner.sv
// Top level of the DNA profile motif scanner: request control, sum wave and result register.
//
// Usage: one input channel (in_valid/in_ready) carries requests: load a profile
// weight, scan one base, or start a new sequence. The output channel
// (out_valid/out_ready) carries the 1-based start of each reported matching window.
// The span register and match_threshold are written through cfg_we/cfg_index/cfg_data
// while the block is idle.
// Loads, new-sequence requests and scans that close no judged window leave in_ready
// high. After a hit, the next span - 1 judged windows are skipped, so reported hits
// do not overlap. A scan that closes any other judged window launches a sum wave
// through the chain of column cells, one cell per cycle, and in_ready stays low
// while the wave runs. The wave passes only the cells of the used span.
// A finished hit waits in the output register; if that register is still held
// by a stalled receiver, the new hit waits in a pending slot and in_ready stays
// low until it moves out.
// Reset clears the window, the counters, the pending and output state, and sets
// the span to 30 and match_threshold to 1.0; profile weights must be loaded
// before use.
module dna_profile_motif_scanner #(
	parameter int MAX_MOTIF    = dpms_pkg::MAX_MOTIF_DEF,
	parameter int MAX_SEQUENCE = dpms_pkg::MAX_SEQUENCE_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [dpms_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [dpms_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic [dpms_pkg::OP_W-1:0]            operation,
	input  logic [dpms_pkg::CHAR_W-1:0]          base_char,
	input  logic [dpms_pkg::COL_W-1:0]           weight_column,
	input  logic [dpms_pkg::BASE_W-1:0]          weight_base,
	input  logic [dpms_pkg::WEIGHT_W-1:0]        weight_value,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic [dpms_pkg::POS_W-1:0]           hit_position
);

	localparam int SUM_W  = dpms_pkg::WEIGHT_W + $clog2(MAX_MOTIF);
	localparam int LEN_W  = $clog2(MAX_MOTIF + 1);
	localparam int SEEN_W = $clog2(MAX_SEQUENCE + 1);
	localparam int IDX_W  = (MAX_MOTIF > 1) ? $clog2(MAX_MOTIF) : 1;

	logic [dpms_pkg::LEN_REG_W-1:0] len_reg_q;
	logic [dpms_pkg::THR_W-1:0]     thr_q;
	logic [LEN_W-1:0]               len;
	logic [IDX_W-1:0]               last_idx;
	logic [SUM_W-1:0]               need_q;
	logic [SEEN_W-1:0]              seen_q;
	dpms_pkg::skip_t                skip_q;
	dpms_pkg::pos_t                 pos_q;
	dpms_pkg::pos_t                 out_pos_q;
	logic                           start_q;
	logic                           busy_q;
	logic                           pend_q;
	logic                           out_valid_q;

	logic                           acc;
	logic                           is_scan;
	logic                           judge;
	logic                           start_wave;
	logic                           done;
	logic                           hit;
	logic                           hit_fire;
	logic                           out_free;
	dpms_pkg::cell_ctl_t            ctl;

	logic [MAX_MOTIF-1:0]           col_en;
	logic [MAX_MOTIF-1:0]           tok_c;
	logic [MAX_MOTIF-1:0]           tok_in_c;
	dpms_pkg::base_t                fwd_base [MAX_MOTIF];
	dpms_pkg::base_t                tap_c    [MAX_MOTIF];
	dpms_pkg::base_t                tap_in_c [MAX_MOTIF];
	logic [SUM_W-1:0]               fsum_c   [MAX_MOTIF];
	logic [SUM_W-1:0]               rsum_c   [MAX_MOTIF];
	logic [SUM_W-1:0]               fsum_in_c[MAX_MOTIF];
	logic [SUM_W-1:0]               rsum_in_c[MAX_MOTIF];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_reg_q <= dpms_pkg::LEN_RESET;
			thr_q     <= dpms_pkg::THR_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				dpms_pkg::REG_LENGTH:    len_reg_q <= cfg_data[dpms_pkg::LEN_REG_W-1:0];
				dpms_pkg::REG_THRESHOLD: thr_q     <= cfg_data;
			endcase
		end
	end

	always_comb begin
		if (len_reg_q == '0) begin
			len = LEN_W'(1);
		end else if (int'(len_reg_q) > MAX_MOTIF) begin
			len = LEN_W'(MAX_MOTIF);
		end else begin
			len = LEN_W'(len_reg_q);
		end
		last_idx = IDX_W'(int'(len) - 1);
	end

	always_ff @(posedge clk) begin
		need_q <= SUM_W'(thr_q) * SUM_W'(len);
	end

	assign in_ready   = !busy_q;
	assign acc        = in_valid && in_ready;
	assign is_scan    = acc && (operation == dpms_pkg::OP_SCAN) &&
	                    (seen_q < SEEN_W'(MAX_SEQUENCE));
	assign judge      = (int'(seen_q) + 1) >= int'(len);
	assign start_wave = is_scan && judge && (skip_q == '0);
	assign out_free   = !out_valid_q || out_ready;

	always_comb begin
		ctl.load     = acc && (operation == dpms_pkg::OP_LOAD);
		ctl.column   = weight_column;
		ctl.wbase    = weight_base;
		ctl.value    = weight_value;
		ctl.shift    = is_scan;
		ctl.new_base = dpms_pkg::base_code(base_char);
		ctl.clear    = acc && (operation == dpms_pkg::OP_NEW);
	end

	// forward strand reads column j against the base len-1-j places back
	always_comb begin
		for (int j = 0; j < MAX_MOTIF; j++) begin
			fwd_base[j] = dpms_pkg::BASE_A;
			col_en[j]   = j < int'(len);
			for (int k = 0; k < MAX_MOTIF; k++) begin
				if (int'(len) - 1 == j + k) begin
					fwd_base[j] = tap_c[k];
				end
			end
		end
	end

	for (genvar j = 0; j < MAX_MOTIF; j++) begin : g_cell
		if (j == 0) begin : g_head
			assign tok_in_c[j]  = start_q;
			assign fsum_in_c[j] = '0;
			assign rsum_in_c[j] = '0;
			assign tap_in_c[j]  = ctl.new_base;
		end else begin : g_link
			assign tok_in_c[j]  = tok_c[j-1];
			assign fsum_in_c[j] = fsum_c[j-1];
			assign rsum_in_c[j] = rsum_c[j-1];
			assign tap_in_c[j]  = tap_c[j-1];
		end

		dpms_cell #(
			.COL   (j),
			.SUM_W (SUM_W)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (ctl),
			.col_en   (col_en[j]),
			.fwd_base (fwd_base[j]),
			.tok_in   (tok_in_c[j]),
			.fsum_in  (fsum_in_c[j]),
			.rsum_in  (rsum_in_c[j]),
			.tap_in   (tap_in_c[j]),
			.tok_out  (tok_c[j]),
			.fsum_out (fsum_c[j]),
			.rsum_out (rsum_c[j]),
			.tap_out  (tap_c[j])
		);
	end

	assign done     = busy_q && tok_c[last_idx];
	assign hit      = (fsum_c[last_idx] >= need_q) || (rsum_c[last_idx] >= need_q);
	assign hit_fire = done && hit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q      <= '0;
			skip_q      <= '0;
			start_q     <= 1'b0;
			busy_q      <= 1'b0;
			pend_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			start_q <= start_wave;

			if (ctl.clear) begin
				seen_q <= '0;
			end else if (is_scan) begin
				seen_q <= seen_q + SEEN_W'(1);
			end

			if (ctl.clear) begin
				skip_q <= '0;
			end else if (is_scan && judge && (skip_q != '0)) begin
				skip_q <= skip_q - dpms_pkg::skip_t'(1);
			end else if (hit_fire) begin
				skip_q <= dpms_pkg::skip_t'(int'(len) - 1);
			end

			if (start_wave) begin
				busy_q <= 1'b1;
			end else if (done && (!hit || out_free)) begin
				busy_q <= 1'b0;
			end else if (pend_q && out_free) begin
				busy_q <= 1'b0;
			end

			if (hit_fire && !out_free) begin
				pend_q <= 1'b1;
			end else if (out_free) begin
				pend_q <= 1'b0;
			end

			if ((hit_fire || pend_q) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start_wave) begin
			pos_q <= dpms_pkg::pos_t'(int'(seen_q) + 2 - int'(len));
		end
		if ((hit_fire || pend_q) && out_free) begin
			out_pos_q <= pos_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign hit_position = out_pos_q;

	a_one_wave: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(tok_c))
		else $error("more than one sum wave in the cell chain");

	a_idle_no_wave: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> ((tok_c == '0) && !start_q))
		else $error("request taken while a sum wave is in flight");

	a_pend_out: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q |-> out_valid_q)
		else $error("pending hit without a held output");

	a_seen_bound: assert property (@(posedge clk) disable iff (!arst_n)
		int'(seen_q) <= MAX_SEQUENCE)
		else $error("base count beyond sequence limit");

	a_skip_load: assert property (@(posedge clk) disable iff (!arst_n)
		hit_fire |=> (int'(skip_q) == $past(int'(len)) - 1))
		else $error("suppression count not loaded after a hit");

endmodule

// File: design/dpms_cell.sv
// One profile column cell: weights, one window tap and one hop of the sum wave.
module dpms_cell #(
	parameter int COL   = 0,
	parameter int SUM_W = 22
) (
	input  logic                clk,
	input  logic                arst_n,
	input  dpms_pkg::cell_ctl_t ctl,
	input  logic                col_en,
	input  dpms_pkg::base_t     fwd_base,
	input  logic                tok_in,
	input  logic [SUM_W-1:0]    fsum_in,
	input  logic [SUM_W-1:0]    rsum_in,
	input  dpms_pkg::base_t     tap_in,
	output logic                tok_out,
	output logic [SUM_W-1:0]    fsum_out,
	output logic [SUM_W-1:0]    rsum_out,
	output dpms_pkg::base_t     tap_out
);

	dpms_pkg::weight_t w_q [4];
	dpms_pkg::base_t   tap_q;
	logic              tok_q;
	logic [SUM_W-1:0]  fsum_q;
	logic [SUM_W-1:0]  rsum_q;
	dpms_pkg::weight_t fterm;
	dpms_pkg::weight_t rterm;

	always_ff @(posedge clk) begin
		if (ctl.load && (32'(ctl.column) == COL)) begin
			w_q[ctl.wbase] <= ctl.value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_q <= dpms_pkg::BASE_A;
			tok_q <= 1'b0;
		end else begin
			if (ctl.clear) begin
				tap_q <= dpms_pkg::BASE_A;
			end else if (ctl.shift) begin
				tap_q <= tap_in;
			end
			// drop the wave past the last column in use
			tok_q <= tok_in && col_en;
		end
	end

	always_comb begin
		fterm = col_en ? w_q[fwd_base] : '0;
		rterm = col_en ? w_q[dpms_pkg::BASE_T - tap_q] : '0;
	end

	always_ff @(posedge clk) begin
		fsum_q <= fsum_in + SUM_W'(fterm);
		rsum_q <= rsum_in + SUM_W'(rterm);
	end

	assign tok_out  = tok_q;
	assign fsum_out = fsum_q;
	assign rsum_out = rsum_q;
	assign tap_out  = tap_q;

endmodule

// File: tb/tb.sv
// Self-checking testbench for dna_profile_motif_scanner: directed and random requests.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import dpms_pkg::*;

	localparam int MOTIF_MAX   = MAX_MOTIF_DEF;
	localparam int SEQ_MAX     = MAX_SEQUENCE_DEF;
	localparam int DRAIN_WAIT  = MOTIF_MAX + 8;
	localparam int STALL_LIMIT = 4000;
	localparam int LONG_HOLD   = 400;

	localparam logic [OP_W-1:0]   OP_NOP = 2'd3;
	localparam logic [CHAR_W-1:0] CHAR_A = 8'h41;

	typedef struct {
		logic [OP_W-1:0]   op;
		logic [CHAR_W-1:0] ch;
		logic [COL_W-1:0]  col;
		base_t             row;
		weight_t           value;
	} request_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	logic [OP_W-1:0]       operation = '0;
	logic [CHAR_W-1:0]     base_char = '0;
	logic [COL_W-1:0]      weight_column = '0;
	base_t                 weight_base = '0;
	weight_t               weight_value = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	pos_t                  hit_position;

	dna_profile_motif_scanner dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.operation(operation),
		.base_char(base_char),
		.weight_column(weight_column),
		.weight_base(weight_base),
		.weight_value(weight_value),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.hit_position(hit_position)
	);

	always #6 clk = ~clk;

	// scanner state as the host sees it
	weight_t             profile_w [MOTIF_MAX*4] = '{default: '0};
	base_t               recent [MOTIF_MAX] = '{default: '0};
	int                  seq_bases = 0;
	int                  skip_left = 0;
	logic [LEN_REG_W-1:0] len_cfg = LEN_RESET;
	logic [THR_W-1:0]    thr_cfg = THR_RESET;
	pos_t                pending_hits [$];

	base_t    consensus [MOTIF_MAX];
	request_t request_queue [$];
	request_t cur_req;
	int       pushed_count = 0;
	int       accepted_count = 0;
	int       burst_left = 20;
	int       gap_left = 0;
	int       mismatch_count = 0;
	pos_t     want;
	int       idle_cycles = 0;
	int       hold_requests = 0;
	int       hold_seen = 0;
	int       hold_left = 0;
	int       mode_left = 0;
	int       ready_mode = 0;

	function automatic int motif_span();
		int span;
		span = int'(len_cfg);
		if (span < 1)
			span = 1;
		if (span > MOTIF_MAX)
			span = MOTIF_MAX;
		return span;
	endfunction

	function automatic base_t char_code(input logic [CHAR_W-1:0] ch);
		base_t b;
		b = BASE_A;
		if (ch == CHAR_C)
			b = BASE_C;
		else if (ch == CHAR_G)
			b = BASE_G;
		else if (ch == CHAR_T)
			b = BASE_T;
		return b;
	endfunction

	function automatic logic [CHAR_W-1:0] code_char(input base_t b);
		logic [CHAR_W-1:0] ch;
		case (b)
			BASE_C:  ch = CHAR_C;
			BASE_G:  ch = CHAR_G;
			BASE_T:  ch = CHAR_T;
			default: ch = CHAR_A;
		endcase
		return ch;
	endfunction

	function automatic logic [CHAR_W-1:0] random_char();
		logic [CHAR_W-1:0] ch;
		if ($urandom_range(0, 9) == 0)
			ch = CHAR_W'($urandom_range(0, 255));
		else
			ch = code_char(base_t'($urandom_range(0, 3)));
		return ch;
	endfunction

	// advance the scanner state by one request, queue the hit it yields
	function automatic void advance_scanner(input request_t r);
		int              span;
		int              b;
		longint unsigned fwd;
		longint unsigned rev;
		longint unsigned need;
		case (r.op)
			OP_LOAD: begin
				if (int'(r.col) < MOTIF_MAX)
					profile_w[int'(r.col)*4 + int'(r.row)] = r.value;
			end
			OP_NEW: begin
				recent = '{default: '0};
				seq_bases = 0;
				skip_left = 0;
			end
			OP_SCAN: begin
				if (seq_bases < SEQ_MAX) begin
					for (int i = 0; i < MOTIF_MAX - 1; i++)
						recent[i] = recent[i+1];
					recent[MOTIF_MAX-1] = char_code(r.ch);
					seq_bases++;
					span = motif_span();
					if (seq_bases >= span) begin
						if (skip_left > 0) begin
							skip_left--;
						end else begin
							fwd = 0;
							rev = 0;
							for (int c = 0; c < span; c++) begin
								b = int'(recent[MOTIF_MAX-span+c]);
								fwd += profile_w[c*4 + b];
								rev += profile_w[(span-1-c)*4 + (3-b)];
							end
							need = longint'(thr_cfg) * span;
							if (fwd >= need || rev >= need) begin
								skip_left = span - 1;
								pending_hits.push_back(pos_t'(seq_bases - span + 1));
							end
						end
					end
				end
			end
			default: begin
			end
		endcase
	endfunction

	task automatic push_request(input logic [OP_W-1:0] op, input logic [CHAR_W-1:0] ch,
		input logic [COL_W-1:0] col, input base_t row, input weight_t value);
		request_t r;
		r.op = op;
		r.ch = ch;
		r.col = col;
		r.row = row;
		r.value = value;
		request_queue.push_back(r);
		pushed_count++;
	endtask

	task automatic push_scan(input logic [CHAR_W-1:0] ch);
		push_request(OP_SCAN, ch, COL_W'($urandom_range(0, 31)), base_t'($urandom_range(0, 3)),
			weight_t'($urandom_range(0, 131071)));
	endtask

	task automatic push_new();
		push_request(OP_NEW, CHAR_W'($urandom_range(0, 255)), COL_W'($urandom_range(0, 31)),
			base_t'($urandom_range(0, 3)), weight_t'($urandom_range(0, 131071)));
	endtask

	// fresh consensus: strong weight on one row per column, weak elsewhere
	task automatic load_profile();
		for (int c = 0; c < MOTIF_MAX; c++) begin
			consensus[c] = base_t'($urandom_range(0, 3));
			for (int b = 0; b < 4; b++) begin
				if (base_t'(b) == consensus[c])
					push_request(OP_LOAD, random_char(), COL_W'(c), base_t'(b),
						weight_t'($urandom_range(45000, 65536)));
				else
					push_request(OP_LOAD, random_char(), COL_W'(c), base_t'(b),
						weight_t'($urandom_range(0, 12000)));
			end
		end
	endtask

	task automatic plant_motif(input bit rev_strand);
		int    span;
		int    flaw;
		base_t b;
		span = motif_span();
		flaw = ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, span - 1)) : -1;
		for (int i = 0; i < span; i++) begin
			b = rev_strand ? base_t'(3 - int'(consensus[span-1-i])) : consensus[i];
			if (i == flaw)
				b = base_t'($urandom_range(0, 3));
			push_scan(code_char(b));
		end
	endtask

	// hold until every request is taken and every hit has come, then let the block settle
	task automatic wait_quiet();
		do
			@(negedge clk);
		while (accepted_count != pushed_count || pending_hits.size() != 0);
		repeat (DRAIN_WAIT) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_LENGTH)
			len_cfg = data[LEN_REG_W-1:0];
		else
			thr_cfg = data[THR_W-1:0];
		@(negedge clk);
	endtask

	task automatic run_phase(input int span_reg, input int thr, input int n, input bit fresh);
		int  sent;
		int  pick;
		bit  paused;
		sent = 0;
		paused = 1'b0;
		wait_quiet();
		write_reg(REG_LENGTH, CFG_DATA_W'(span_reg));
		write_reg(REG_THRESHOLD, CFG_DATA_W'(thr));
		if (fresh)
			push_new();
		while (sent < n) begin
			if (!paused && sent >= n / 2) begin
				wait_quiet();
				paused = 1'b1;
			end
			pick = $urandom_range(0, 99);
			if (pick < 45) begin
				plant_motif(1'($urandom_range(0, 1)));
				sent += motif_span();
			end else begin
				if (pick < 90)
					push_scan(random_char());
				else if (pick < 94)
					push_request(OP_LOAD, random_char(), COL_W'($urandom_range(0, 31)),
						base_t'($urandom_range(0, 3)),
						($urandom_range(0, 3) == 0) ? weight_t'($urandom_range(0, 131071))
							: weight_t'($urandom_range(0, 65536)));
				else if (pick < 97)
					push_request(OP_NOP, CHAR_W'($urandom_range(0, 255)),
						COL_W'($urandom_range(0, 31)), base_t'($urandom_range(0, 3)),
						weight_t'($urandom_range(0, 131071)));
				else
					push_new();
				sent++;
			end
		end
	endtask

	// request driver
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				advance_scanner(cur_req);
				accepted_count++;
			end
			if (!in_valid || in_ready) begin
				if (gap_left > 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (request_queue.size() != 0) begin
					cur_req = request_queue.pop_front();
					operation <= cur_req.op;
					base_char <= cur_req.ch;
					weight_column <= cur_req.col;
					weight_base <= cur_req.row;
					weight_value <= cur_req.value;
					in_valid <= 1'b1;
					if (burst_left <= 1) begin
						burst_left = $urandom_range(1, 80);
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
					end else begin
						burst_left--;
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// hit receiver
	always @(posedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else if (hold_seen != hold_requests) begin
			hold_seen = hold_requests;
			hold_left = LONG_HOLD;
			out_ready <= 1'b0;
		end else begin
			if (mode_left == 0) begin
				ready_mode = $urandom_range(0, 3);
				mode_left = $urandom_range(20, 200);
			end
			mode_left--;
			case (ready_mode)
				0:       out_ready <= 1'b1;
				1:       out_ready <= 1'($urandom_range(0, 1));
				2:       out_ready <= ($urandom_range(0, 3) == 0);
				default: out_ready <= ~out_ready;
			endcase
		end
	end

	// hit monitor
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_hits.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("unexpected hit_position %0d with no hit pending", hit_position);
			end else begin
				want = pending_hits.pop_front();
				if (hit_position !== want) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("hit_position mismatch: expected %0d, got %0d",
							want, hit_position);
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
	end

	initial begin
		while (idle_cycles < STALL_LIMIT)
			@(posedge clk);
		$display("dna_profile_motif_scanner verification failed");
		$finish;
	end

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		write_reg(REG_LENGTH, CFG_DATA_W'(4));
		write_reg(REG_THRESHOLD, CFG_DATA_W'(50000));
		load_profile();

		push_request(OP_NOP, 8'hFF, 5'd31, 2'd3, 17'h1FFFF);
		push_request(OP_LOAD, 8'h00, 5'd31, 2'd3, 17'h1FFFF);
		push_request(OP_LOAD, 8'h00, 5'd30, 2'd0, 17'h1FFFF);
		push_request(OP_LOAD, 8'hFF, 5'd0, consensus[0], 17'h1FFFF);
		push_request(OP_LOAD, 8'h00, 5'd29, 2'd2, 17'h00000);
		push_new();
		push_scan(8'h00);
		push_scan(8'hFF);
		push_scan(8'h61);
		plant_motif(1'b0);
		plant_motif(1'b1);
		push_scan(CHAR_A);
		push_scan(CHAR_C);
		push_scan(CHAR_G);
		push_scan(CHAR_T);

		run_phase(1, 30000, 150, 1'b1);
		run_phase(30, 50000, 200, 1'b1);
		run_phase(0, 20000, 150, 1'b1);
		run_phase(31, 45000, 200, 1'b0);
		repeat (2) begin
			wait_quiet();
			load_profile();
			run_phase($urandom_range(2, 29), $urandom_range(20000, 60000), 180,
				$urandom_range(0, 3) != 0);
		end
		wait_quiet();
		hold_requests++;
		run_phase(3, 0, 150, 1'b1);
		run_phase(9, 0, 120, 1'b0);
		run_phase(7, 65536, 150, 1'b1);
		run_phase(5, 131071, 100, 1'b1);

		wait_quiet();
		if (mismatch_count == 0 && pending_hits.size() == 0)
			$display("dna_profile_motif_scanner verification clean");
		else
			$display("dna_profile_motif_scanner verification failed");
		$finish;
	end

endmodule
